// ----- sv/twmd_pkg.sv -----
// shared types and constants of the trigger word mask decoder
package twmd_pkg;

    localparam int unsigned HEADER_SKIP  = 4;
    localparam int unsigned MASK_BITS    = 32;
    localparam int unsigned SKIP_W       = 3;
    localparam int unsigned SLOT_W       = 31;

    localparam logic [31:0]       MASK_LIMIT   = 32'((64'd1 << MASK_BITS) - 64'd1);
    localparam logic [SKIP_W-1:0] SKIP_LOAD    = SKIP_W'(HEADER_SKIP);
    localparam logic [31:0]       HDR_WORDS    = 32'd4;
    localparam logic [4:0]        TRIG_TAG     = 5'h1D;
    localparam logic [7:0]        CRATE_RESET  = 8'd100;

    typedef enum logic [3:0] {
        PH_SCAN    = 4'b0001,
        PH_SKIP    = 4'b0010,
        PH_FIRST   = 4'b0100,
        PH_PARTNER = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0]  crate_id;
        logic [31:0] data_word;
        logic        end_of_event;
    } t_row;

endpackage

// ----- sv/trigger_word_mask_decoder.sv -----
// top level of the trigger word mask decoder
//
// one bank row (crate id, data word, end-of-event flag) is taken per clock cycle,
// continuously, as long as the result side keeps up. a row is registered in the input
// register, is parsed there, and when the end-of-event row steps out of it the event
// mask is loaded into the result register and offered from there. rows that do not
// end an event give no result. the input register stalls only when an end-of-event
// row meets a result register that is still full and not being taken. the trigger
// crate id register (reset 100) is written through the configuration channel, which
// is always ready; write it only while no event is in flight.
module trigger_word_mask_decoder
    import twmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_trigger_crate_id,
    // row input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_crate_id,
    input  logic [31:0] i_data_word,
    input  logic        i_end_of_event,
    // mask output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_trigger_mask
);

    logic [7:0]  r_trig_crate;
    t_row        w_in_row;
    t_row        w_stage_row;
    logic        w_stage_valid;
    logic        w_step;
    logic        w_out_free;
    logic [31:0] w_mask;

    // configuration register, no back-pressure
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_crate <= CRATE_RESET;
        end else if (i_cfg_valid) begin
            r_trig_crate <= i_cfg_trigger_crate_id;
        end
    end

    assign w_in_row = '{crate_id: i_crate_id, data_word: i_data_word,
                        end_of_event: i_end_of_event};

    // a row steps through the parser unless it ends an event and the
    // result register has no room this cycle
    assign w_step = w_stage_valid && (!w_stage_row.end_of_event || w_out_free);

    twmd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_row   (w_in_row),
        .o_valid (w_stage_valid),
        .i_take  (w_step),
        .o_row   (w_stage_row)
    );

    twmd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_row        (w_stage_row),
        .i_trig_crate (r_trig_crate),
        .o_mask       (w_mask)
    );

    // the event mask is loaded only on the end-of-event row
    twmd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step && w_stage_row.end_of_event),
        .i_mask  (w_mask),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_mask  (o_trigger_mask)
    );

endmodule

// ----- sv/twmd_in_reg.sv -----
// input register holding one bank row ahead of the parser
module twmd_in_reg
    import twmd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_row i_row,
    output logic o_valid,
    input  logic i_take,
    output t_row o_row
);

    logic r_valid;
    logic n_valid;
    t_row r_row;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_row   = r_row;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_row <= i_row;
        end
    end

endmodule

// ----- sv/twmd_parser.sv -----
// bank row parser: header, skip and trigger slot phases plus event mask
module twmd_parser
    import twmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_row        i_row,
    input  logic [7:0]  i_trig_crate,
    output logic [31:0] o_mask
);

    t_phase              r_phase;
    t_phase              n_phase;
    logic [SKIP_W-1:0]   r_skip;
    logic [SKIP_W-1:0]   n_skip;
    logic [SLOT_W-1:0]   r_slots;
    logic [SLOT_W-1:0]   n_slots;
    logic [15:0]         r_held;
    logic [15:0]         n_held;
    logic [31:0]         r_accum;
    logic [31:0]         n_accum;
    logic [31:0]         v_accum;
    logic [31:0]         v_count;

    // word count minus the fixed header words, two words per slot
    assign v_count = i_row.data_word - HDR_WORDS;

    always_comb begin
        n_phase = r_phase;
        n_skip  = r_skip;
        n_slots = r_slots;
        n_held  = r_held;
        v_accum = r_accum;
        if (i_step) begin
            unique case (r_phase)
                PH_SCAN: begin
                    if (i_row.crate_id == i_trig_crate) begin
                        n_slots = (i_row.data_word > HDR_WORDS) ? v_count[31:1] : '0;
                        n_skip  = SKIP_LOAD;
                        if (SKIP_LOAD != '0) begin
                            n_phase = PH_SKIP;
                        end else begin
                            n_phase = (n_slots != '0) ? PH_FIRST : PH_SCAN;
                        end
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - 1'b1;
                    if (n_skip == '0) begin
                        n_phase = (r_slots != '0) ? PH_FIRST : PH_SCAN;
                    end
                end
                PH_FIRST: begin
                    if (i_row.data_word[31:27] == TRIG_TAG) begin
                        n_held  = i_row.data_word[15:0];
                        n_phase = PH_PARTNER;
                    end else begin
                        n_slots = r_slots - 1'b1;
                        n_phase = (n_slots != '0) ? PH_FIRST : PH_SCAN;
                    end
                end
                PH_PARTNER: begin
                    v_accum = (r_accum | {i_row.data_word[15:0], r_held}) & MASK_LIMIT;
                    n_held  = '0;
                    n_slots = r_slots - 1'b1;
                    n_phase = (n_slots != '0) ? PH_FIRST : PH_SCAN;
                end
                default: begin
                    n_phase = PH_SCAN;
                    n_skip  = '0;
                    n_slots = '0;
                    n_held  = '0;
                    v_accum = '0;
                end
            endcase
        end
        n_accum = v_accum;
        // end of event: mask goes out, parser starts afresh
        if (i_step && i_row.end_of_event) begin
            n_phase = PH_SCAN;
            n_skip  = '0;
            n_slots = '0;
            n_held  = '0;
            n_accum = '0;
        end
    end

    assign o_mask = v_accum & MASK_LIMIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SCAN;
            r_skip  <= '0;
            r_slots <= '0;
            r_held  <= '0;
            r_accum <= '0;
        end else begin
            r_phase <= n_phase;
            r_skip  <= n_skip;
            r_slots <= n_slots;
            r_held  <= n_held;
            r_accum <= n_accum;
        end
    end

endmodule

// ----- sv/twmd_out_reg.sv -----
// result register holding one event mask until the transfer completes
module twmd_out_reg
    import twmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [31:0] i_mask,
    output logic        o_free,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_mask
);

    logic        r_valid;
    logic        n_valid;
    logic [31:0] r_mask;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_mask  = r_mask;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mask <= i_mask & MASK_LIMIT;
        end
    end

endmodule

// ----- sv/twmd_checker.sv -----
// port-level checker of the trigger word mask decoder and its bind
module twmd_checker
    import twmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_ready,
    input  logic        i_end_of_event,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] o_trigger_mask
);

    // result held until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_trigger_mask))
        else $error("mask changed while stalled");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    // a fresh result follows an earlier end-of-event row transfer
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && i_end_of_event, 2))
        else $error("result without end-of-event row");

endmodule

bind trigger_word_mask_decoder twmd_checker u_twmd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_end_of_event (i_end_of_event),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_trigger_mask (o_trigger_mask)
);
